// ----- rtl/d2xyz_pkg.sv -----
// Shared types and constants of the depth-to-point back-projection block.
`default_nettype none

package d2xyz_pkg;

    // Field and register widths.
    localparam int DEPTH_W     = 24;
    localparam int COORD_W     = 32;
    localparam int DIM_CFG_W   = 13;
    localparam int CENTER_W    = 16;
    localparam int INV_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Multiplier staging: |diff| * z, then that product split in two halves.
    localparam int ABS_DIFF_W  = 16;
    localparam int ZMAG_W      = DEPTH_W - 1;
    localparam int M1_W        = ABS_DIFF_W + ZMAG_W;
    localparam int M1_LO_W     = 20;
    localparam int M1_HI_W     = M1_W - M1_LO_W;
    localparam int PLO_W       = M1_LO_W + INV_W;
    localparam int PHI_W       = M1_HI_W + INV_W;
    localparam int PROD_W      = M1_W + INV_W;
    localparam int FRAC_SHIFT  = 28;
    localparam int QUOT_W      = PROD_W - FRAC_SHIFT;

    // Value reported for a pixel without a measurement (-1.0 in Q.10).
    localparam logic signed [COORD_W-1:0] INVALID_COORD = -32'sd1024;
    localparam logic signed [DEPTH_W-1:0] INVALID_DEPTH = -24'sd1024;

    // Register reset values.
    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET    = 13'd640;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET   = 13'd480;
    localparam logic [CENTER_W-1:0]  CENTER_X_RESET = 16'd5120;
    localparam logic [CENTER_W-1:0]  CENTER_Y_RESET = 16'd3840;
    localparam logic [INV_W-1:0]     INV_FX_RESET   = 24'd32264;
    localparam logic [INV_W-1:0]     INV_FY_RESET   = 24'd32264;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_INV_FOCAL_X  = 3'd4,
        REG_INV_FOCAL_Y  = 3'd5
    } cfg_reg_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul_diff;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic load_out;
    } d2xyz_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/d2xyz_lane.sv -----
// One coordinate lane: (pos*16 - center) * z * inv, floored by 2^28 and saturated.
`default_nettype none

module d2xyz_lane #(
    parameter int DIM_W = 12
) (
    input  wire logic                          clk,
    input  wire d2xyz_pkg::d2xyz_cmd_t         cmd,
    input  wire logic [DIM_W-1:0]              pos,
    input  wire logic [d2xyz_pkg::CENTER_W-1:0] center,
    input  wire logic [d2xyz_pkg::INV_W-1:0]   inv,
    input  wire logic [d2xyz_pkg::DEPTH_W-1:0] depth,
    output logic signed [d2xyz_pkg::COORD_W-1:0] coord
);
    import d2xyz_pkg::*;

    logic                  neg_reg;
    logic [ABS_DIFF_W-1:0] abs_diff_reg;
    logic [ZMAG_W-1:0]     zmag_reg;
    logic [INV_W-1:0]      inv_reg;
    logic [M1_W-1:0]       m1_reg;
    logic [PLO_W-1:0]      plo_reg;
    logic [PHI_W-1:0]      phi_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic [ABS_DIFF_W:0]   pos_q4;
    logic [ABS_DIFF_W:0]   center_ext;
    logic [ABS_DIFF_W-1:0] abs_diff;
    logic [QUOT_W-1:0]     quot;
    logic                  frac_nz;
    logic [QUOT_W:0]       quot_ceil;

    // Column or row in Q.4, compared against the principal point.
    assign pos_q4     = (ABS_DIFF_W + 1)'(pos) << 4;
    assign center_ext = {1'b0, center};
    assign abs_diff   = (pos_q4 < center_ext) ? ABS_DIFF_W'(center_ext - pos_q4)
                                              : ABS_DIFF_W'(pos_q4 - center_ext);

    // Multiply sequence on magnitudes; the sign is applied at the end.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg      <= (pos_q4 < center_ext);
            abs_diff_reg <= abs_diff;
            zmag_reg     <= depth[ZMAG_W-1:0];
            inv_reg      <= inv;
        end
        if (cmd.mul_diff)
        begin
            m1_reg <= M1_W'(abs_diff_reg) * M1_W'(zmag_reg);
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= PLO_W'(m1_reg[M1_LO_W-1:0]) * PLO_W'(inv_reg);
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= PHI_W'(m1_reg[M1_W-1:M1_LO_W]) * PHI_W'(inv_reg);
        end
        if (cmd.sum)
        begin
            prod_reg <= PROD_W'(plo_reg) + (PROD_W'(phi_reg) << M1_LO_W);
        end
    end

    // Floor division by 2^28: a negative value rounds its magnitude up.
    assign quot      = prod_reg[PROD_W-1:FRAC_SHIFT];
    assign frac_nz   = |prod_reg[FRAC_SHIFT-1:0];
    assign quot_ceil = (QUOT_W + 1)'(quot) + (QUOT_W + 1)'(frac_nz);

    // Saturate to the signed 32-bit range.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (|quot[QUOT_W-1:COORD_W-1])
                coord = {1'b0, {(COORD_W-1){1'b1}}};
            else
                coord = COORD_W'(quot);
        end
        else
        begin
            if (quot_ceil > ((QUOT_W + 1)'(1) << (COORD_W - 1)))
                coord = {1'b1, {(COORD_W-1){1'b0}}};
            else
                coord = COORD_W'((QUOT_W + 1)'(0) - quot_ceil);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/d2xyz_datapath.sv -----
// Datapath: configuration registers, pixel counters, two coordinate lanes, result register.
`default_nettype none

module d2xyz_datapath #(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [d2xyz_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [d2xyz_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire d2xyz_pkg::d2xyz_cmd_t             cmd,
    input  wire logic signed [d2xyz_pkg::DEPTH_W-1:0] depth,
    output logic signed [d2xyz_pkg::COORD_W-1:0]   point_x,
    output logic signed [d2xyz_pkg::COORD_W-1:0]   point_y,
    output logic signed [d2xyz_pkg::DEPTH_W-1:0]   point_z,
    output logic                                   point_valid,
    output logic [DIM_W-1:0]                       pixel_col,
    output logic [DIM_W-1:0]                       pixel_row,
    output logic                                   frame_end
);
    import d2xyz_pkg::*;

    localparam logic [DIM_CFG_W-1:0] DIM_LIMIT = DIM_CFG_W'(MAX_DIM);

    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic [CENTER_W-1:0]  center_x_reg;
    logic [CENTER_W-1:0]  center_y_reg;
    logic [INV_W-1:0]     inv_fx_reg;
    logic [INV_W-1:0]     inv_fy_reg;
    logic [DIM_W-1:0]     col_reg;
    logic [DIM_W-1:0]     row_reg;
    logic [DIM_W-1:0]     col_next;
    logic [DIM_W-1:0]     row_next;

    logic [DEPTH_W-1:0]   z_reg;
    logic                 zvalid_reg;
    logic [DIM_W-1:0]     col_hold_reg;
    logic [DIM_W-1:0]     row_hold_reg;
    logic                 last_hold_reg;

    logic [DIM_CFG_W-1:0] width_eff;
    logic [DIM_CFG_W-1:0] height_eff;
    logic                 row_last;
    logic                 frame_last;
    logic                 depth_pos;
    logic signed [COORD_W-1:0] lane_x;
    logic signed [COORD_W-1:0] lane_y;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            center_x_reg <= CENTER_X_RESET;
            center_y_reg <= CENTER_Y_RESET;
            inv_fx_reg   <= INV_FX_RESET;
            inv_fy_reg   <= INV_FY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg    <= cfg_data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg   <= cfg_data[DIM_CFG_W-1:0];
                REG_CENTER_X:     center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:     center_y_reg <= cfg_data[CENTER_W-1:0];
                REG_INV_FOCAL_X:  inv_fx_reg   <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:  inv_fy_reg   <= cfg_data[INV_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame size clamped to 1..MAX_DIM.
    assign width_eff  = (width_reg == '0) ? DIM_CFG_W'(1)
                      : (width_reg > DIM_LIMIT) ? DIM_LIMIT : width_reg;
    assign height_eff = (height_reg == '0) ? DIM_CFG_W'(1)
                      : (height_reg > DIM_LIMIT) ? DIM_LIMIT : height_reg;

    // End of row and frame; a counter at or past a shrunken limit also wraps.
    assign row_last   = ((DIM_CFG_W + 1)'(col_reg) + 1'b1) >= (DIM_CFG_W + 1)'(width_eff);
    assign frame_last = row_last &&
                        (((DIM_CFG_W + 1)'(row_reg) + 1'b1) >= (DIM_CFG_W + 1)'(height_eff));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_last)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : DIM_W'(row_reg + 1'b1);
        end
        else
        begin
            col_next = DIM_W'(col_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Capture the item and its pixel position.
    assign depth_pos = !depth[DEPTH_W-1] && (depth != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            z_reg         <= depth;
            zvalid_reg    <= depth_pos;
            col_hold_reg  <= col_reg;
            row_hold_reg  <= row_reg;
            last_hold_reg <= frame_last;
        end
    end

    d2xyz_lane #(.DIM_W(DIM_W)) u_lane_x (
        .clk    (clk),
        .cmd    (cmd),
        .pos    (col_reg),
        .center (center_x_reg),
        .inv    (inv_fx_reg),
        .depth  (depth),
        .coord  (lane_x)
    );

    d2xyz_lane #(.DIM_W(DIM_W)) u_lane_y (
        .clk    (clk),
        .cmd    (cmd),
        .pos    (row_reg),
        .center (center_y_reg),
        .inv    (inv_fy_reg),
        .depth  (depth),
        .coord  (lane_y)
    );

    // Result register; pixels without a measurement report -1.0.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            point_x     <= zvalid_reg ? lane_x : INVALID_COORD;
            point_y     <= zvalid_reg ? lane_y : INVALID_COORD;
            point_z     <= zvalid_reg ? z_reg : INVALID_DEPTH;
            point_valid <= zvalid_reg;
            pixel_col   <= col_hold_reg;
            pixel_row   <= row_hold_reg;
            frame_end   <= last_hold_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/d2xyz_ctrl.sv -----
// Controller: steps one item through the multiply sequence and owns the output valid.
`default_nettype none

module d2xyz_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output d2xyz_pkg::d2xyz_cmd_t  cmd
);
    import d2xyz_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Step commands follow the state.
    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
        cmd.mul_diff = (state_reg == ST_MUL_DIFF);
        cmd.mul_lo   = (state_reg == ST_MUL_LO);
        cmd.mul_hi   = (state_reg == ST_MUL_HI);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.load_out = (state_reg == ST_DONE) && out_free;
    end

    // Next state and output valid.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     state_next = in_valid ? ST_MUL_DIFF : ST_IDLE;
            ST_MUL_DIFF: state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_DONE;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/depth_to_xyz_backprojection_top.sv -----
// Top level of the pinhole depth back-projection block.
//
// Input channel: one depth sample (signed Q.10) per item, in raster order.
// A column and a row counter follow the configured frame size and wrap at the
// end of each row and frame. Each input item gives exactly one result item:
// x, y, z in Q.10, a valid flag, the pixel column and row, and a frame end mark.
// Depths of zero or below give -1.0 in all three coordinates and a clear flag.
//
// Handshake: an item is taken when in_valid is high and in_stall is low. Its
// result is loaded into the result register in the same cycle that in_stall
// drops. The path through the block is the multiply sequence: |col*16 - cx| * z,
// then two partial products with the reciprocal, their sum, and the floor and
// saturation into the result register. A result waiting under out_stall holds,
// and while it waits the next item is taken and computed; it then waits in the
// last step until the register frees.
//
// Reset (rst_n low, asynchronous) clears the counters and output valid and loads
// the register defaults. Configuration writes, taken unchecked at any edge with
// cfg_write high, must be made by the user only while no item is in flight.
`default_nettype none

module depth_to_xyz_backprojection_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [d2xyz_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [d2xyz_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [d2xyz_pkg::DEPTH_W-1:0]   depth,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [d2xyz_pkg::COORD_W-1:0]        point_x,
    output logic signed [d2xyz_pkg::COORD_W-1:0]        point_y,
    output logic signed [d2xyz_pkg::DEPTH_W-1:0]        point_z,
    output logic                                        point_valid,
    output logic [$clog2(MAX_DIM)-1:0]                  pixel_col,
    output logic [$clog2(MAX_DIM)-1:0]                  pixel_row,
    output logic                                        frame_end
);
    import d2xyz_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);

    d2xyz_cmd_t cmd;

    d2xyz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    d2xyz_datapath #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .depth       (depth),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_valid (point_valid),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

// ----- rtl/d2xyz_checker.sv -----
// Port-level checks of the back-projection block and their bind to the top level.
`default_nettype none

module d2xyz_checker #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic signed [d2xyz_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [d2xyz_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [d2xyz_pkg::DEPTH_W-1:0] point_z,
    input  wire logic                                 point_valid,
    input  wire logic [$clog2(MAX_DIM)-1:0]           pixel_col,
    input  wire logic [$clog2(MAX_DIM)-1:0]           pixel_row
);
    import d2xyz_pkg::*;

    // A waiting result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result valid dropped while stalled");

    // A waiting result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(point_x) && $stable(point_y)
                                   && $stable(pixel_col) && $stable(pixel_row))
        else $error("result payload changed while stalled");

    // One item at a time: the input is closed right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open in the cycle after an accept");

    // A pixel without a measurement reports -1.0 everywhere.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> point_x == INVALID_COORD
                                      && point_y == INVALID_COORD
                                      && point_z == INVALID_DEPTH)
        else $error("invalid pixel with coordinates other than -1.0");

    // A measured pixel passes a positive depth through.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> point_z > 0)
        else $error("valid pixel with nonpositive depth");

endmodule

bind depth_to_xyz_backprojection_top d2xyz_checker #(.MAX_DIM(MAX_DIM)) u_d2xyz_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row)
);

`default_nettype wire

// ----- dv/tb_depth_to_xyz_backprojection_top.sv -----
// Self-checking testbench for the depth-to-point back-projection block.
`timescale 1ns / 100ps

module tb_depth_to_xyz_backprojection_top;

    import d2xyz_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int DEPTH_TARGET   = 1300;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_INDEX_B = 3'd7;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -24'sh800000;
    localparam logic [INV_W-1:0] INV_MAX = 24'hFFFFFF;
    localparam logic [CENTER_W-1:0] CENTER_MAX = 16'hFFFF;

    // One back-projected pixel as it leaves the block.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [DEPTH_W-1:0] z;
        logic                      valid;
        logic [11:0]               col;
        logic [11:0]               row;
        logic                      last;
    } point_rec_t;

    // Predicts each point from its depth and keeps the points still owed.
    class point_checker;
        logic [DIM_CFG_W-1:0] width_reg;
        logic [DIM_CFG_W-1:0] height_reg;
        logic [CENTER_W-1:0]  cx_reg;
        logic [CENTER_W-1:0]  cy_reg;
        logic [INV_W-1:0]     ifx_reg;
        logic [INV_W-1:0]     ify_reg;
        logic [11:0]          col_at;
        logic [11:0]          row_at;
        point_rec_t           points_due[$];
        int                   bad_points;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            cx_reg     = CENTER_X_RESET;
            cy_reg     = CENTER_Y_RESET;
            ifx_reg    = INV_FX_RESET;
            ify_reg    = INV_FY_RESET;
            col_at     = '0;
            row_at     = '0;
            bad_points = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[DIM_CFG_W-1:0];
                REG_CENTER_X:     cx_reg     = data[CENTER_W-1:0];
                REG_CENTER_Y:     cy_reg     = data[CENTER_W-1:0];
                REG_INV_FOCAL_X:  ifx_reg    = data[INV_W-1:0];
                REG_INV_FOCAL_Y:  ify_reg    = data[INV_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return points_due.size();
        endfunction

        // (pos*16 - center) * z * inv, floored by 2^28 and saturated to 32 bits.
        function logic signed [COORD_W-1:0] scale_axis(logic [11:0] pos,
                logic [CENTER_W-1:0] center, logic signed [DEPTH_W-1:0] z,
                logic [INV_W-1:0] inv);
            longint offs;
            longint scaled;
            offs   = longint'({pos, 4'b0000}) - longint'(center);
            scaled = offs * longint'(z) * longint'(inv);
            scaled = scaled >>> FRAC_SHIFT;
            if (scaled > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (scaled < -64'sd2147483648)
                return 32'sh80000000;
            return 32'(scaled);
        endfunction

        function void take_depth(logic signed [DEPTH_W-1:0] d);
            point_rec_t p;
            int         w;
            int         h;
            bit         row_done;
            bit         frame_done;
            // Sizes outside 1..MAX_DIM are clamped.
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_DIM) ? MAX_DIM : int'(width_reg));
            h = (height_reg == 0) ? 1 : ((height_reg > MAX_DIM) ? MAX_DIM : int'(height_reg));
            row_done   = (int'(col_at) + 1) >= w;
            frame_done = row_done && ((int'(row_at) + 1) >= h);
            if (d > 0)
            begin
                p.x     = scale_axis(col_at, cx_reg, d, ifx_reg);
                p.y     = scale_axis(row_at, cy_reg, d, ify_reg);
                p.z     = d;
                p.valid = 1'b1;
            end
            else
            begin
                p.x     = INVALID_COORD;
                p.y     = INVALID_COORD;
                p.z     = INVALID_DEPTH;
                p.valid = 1'b0;
            end
            p.col  = col_at;
            p.row  = row_at;
            p.last = frame_done;
            points_due = {points_due, p};
            // A counter at or past a reduced limit wraps on this pixel.
            if (row_done)
            begin
                col_at = '0;
                row_at = frame_done ? 12'd0 : row_at + 12'd1;
            end
            else
            begin
                col_at = col_at + 12'd1;
            end
        endfunction

        function void check_point(point_rec_t got);
            point_rec_t want;
            if (points_due.size() == 0)
            begin
                bad_points++;
                if (bad_points <= 10)
                    $display("point at col %0d row %0d arrived with none owed",
                             got.col, got.row);
                return;
            end
            want = points_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.valid !== want.valid || got.col !== want.col ||
                got.row !== want.row || got.last !== want.last)
            begin
                bad_points++;
                if (bad_points <= 10)
                begin
                    $display("point mismatch, expected: x %0d y %0d z %0d valid %0b",
                             want.x, want.y, want.z, want.valid,
                             " col %0d row %0d end %0b", want.col, want.row, want.last);
                    $display("                actual:   x %0d y %0d z %0d valid %0b",
                             got.x, got.y, got.z, got.valid,
                             " col %0d row %0d end %0b", got.col, got.row, got.last);
                end
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [DEPTH_W-1:0]     depth;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [COORD_W-1:0]     point_x;
    logic signed [COORD_W-1:0]     point_y;
    logic signed [DEPTH_W-1:0]     point_z;
    logic                          point_valid;
    logic [11:0]                   pixel_col;
    logic [11:0]                   pixel_row;
    logic                          frame_end;

    point_checker chk;
    bit           calm_phase;
    int           depths_sent;

    depth_to_xyz_backprojection_top #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .depth      (depth),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .point_valid(point_valid),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .frame_end  (frame_end)
    );

    // Clock generation.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, a few long; none in a calm phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Depths: mostly positive over the full range, with zero, negatives and extremes.
    function automatic logic signed [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return DEPTH_W'($urandom_range(1, 24'h7FFFFF));
        else if (r < 65)
            return DEPTH_W'($urandom_range(1, 8192));
        else if (r < 75)
            return (r < 70) ? DEPTH_MAX : 24'sd1;
        else if (r < 85)
            return 24'sd0;
        else if (r < 90)
            return (r < 88) ? -24'sd1 : DEPTH_MIN;
        return {1'b1, 23'($urandom)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return CFG_DATA_W'($urandom_range(1, 12));
        else if (r < 85)
            return CFG_DATA_W'($urandom_range(13, 64));
        else if (r < 95)
        begin
            case ($urandom_range(0, 3))
                0: return 24'd0;
                1: return 24'd1;
                2: return 24'd4096;
                default: return 24'd8191;
            endcase
        end
        return CFG_DATA_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CFG_DATA_W'($urandom_range(0, 200));
        else if (r < 80)
            return CFG_DATA_W'($urandom_range(0, 65535));
        return (r < 90) ? 24'd0 : 24'(CENTER_MAX);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_inv();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
        else if (r < 80)
            return CFG_DATA_W'($urandom_range(1, 100000));
        else if (r < 87)
            return 24'd0;
        else if (r < 93)
            return 24'd1;
        return INV_MAX;
    endfunction

    // Configuration write; entered and left at a falling edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        chk.write_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one depth item, holding it until the block takes it.
    task automatic send_depth(input logic signed [DEPTH_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        depth    <= d;
        do
            @(posedge clk);
        while (in_stall);
        chk.take_depth(d);
        depths_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every owed point has come back.
    task automatic drain_points();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (chk.pending() != 0);
    endtask

    // Rewrites a random subset of the registers while the block is idle.
    task automatic shuffle_config();
        if ($urandom_range(0, 99) < 60) write_reg(REG_FRAME_WIDTH, pick_dim());
        if ($urandom_range(0, 99) < 60) write_reg(REG_FRAME_HEIGHT, pick_dim());
        if ($urandom_range(0, 99) < 60) write_reg(REG_CENTER_X, pick_center());
        if ($urandom_range(0, 99) < 60) write_reg(REG_CENTER_Y, pick_center());
        if ($urandom_range(0, 99) < 60) write_reg(REG_INV_FOCAL_X, pick_inv());
        if ($urandom_range(0, 99) < 60) write_reg(REG_INV_FOCAL_Y, pick_inv());
        if ($urandom_range(0, 99) < 5)  write_reg(UNMAPPED_INDEX_B, 24'($urandom));
    endtask

    // Receiver: random stalls, none during a calm phase.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Every accepted point is compared against the oldest owed one.
    always @(posedge clk)
    begin
        point_rec_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.x     = point_x;
            got.y     = point_y;
            got.z     = point_z;
            got.valid = point_valid;
            got.col   = pixel_col;
            got.row   = pixel_row;
            got.last  = frame_end;
            chk.check_point(got);
        end
    end

    // Main stimulus.
    initial
    begin
        int phase_len;
        int n;
        chk         = new();
        depths_sent = 0;
        calm_phase  = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        depth       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: depth extremes, zero and negatives.
        send_depth(24'sd1);
        send_depth(DEPTH_MAX);
        send_depth(24'sd0);
        send_depth(-24'sd1);
        send_depth(DEPTH_MIN);
        send_depth(24'sd1024);
        send_depth(24'sd2048);
        drain_points();

        // A write to an unmapped index must change nothing.
        write_reg(UNMAPPED_INDEX_A, INV_MAX);
        send_depth(24'sd1024);
        drain_points();

        // Width shrunk below the current column: this pixel ends the row.
        // Far principal point and largest reciprocal drive x into saturation.
        write_reg(REG_FRAME_WIDTH, 24'd3);
        write_reg(REG_FRAME_HEIGHT, 24'd2);
        write_reg(REG_CENTER_X, 24'(CENTER_MAX));
        write_reg(REG_CENTER_Y, 24'd0);
        write_reg(REG_INV_FOCAL_X, INV_MAX);
        write_reg(REG_INV_FOCAL_Y, INV_MAX);
        send_depth(DEPTH_MAX);
        send_depth(DEPTH_MAX);
        send_depth(-24'sd5);
        send_depth(DEPTH_MAX);
        send_depth(24'sd1);
        drain_points();

        // Zero sizes act as one pixel per frame; zero reciprocal gives zero x.
        write_reg(REG_FRAME_WIDTH, 24'd0);
        write_reg(REG_FRAME_HEIGHT, 24'd0);
        write_reg(REG_CENTER_X, 24'd0);
        write_reg(REG_CENTER_Y, 24'(CENTER_MAX));
        write_reg(REG_INV_FOCAL_X, 24'd0);
        write_reg(REG_INV_FOCAL_Y, 24'd1);
        send_depth(DEPTH_MAX);
        send_depth(24'sd1);
        send_depth(-24'sd1024);
        send_depth(24'sd500);
        drain_points();

        // Oversized frame dimensions clamp to the maximum.
        write_reg(REG_FRAME_WIDTH, 24'd8191);
        write_reg(REG_FRAME_HEIGHT, 24'd8191);
        write_reg(REG_CENTER_X, 24'd32768);
        write_reg(REG_CENTER_Y, 24'd16);
        write_reg(REG_INV_FOCAL_X, 24'd1);
        write_reg(REG_INV_FOCAL_Y, 24'd0);
        send_depth(DEPTH_MAX);
        send_depth(24'sd123456);
        send_depth(24'sd0);
        send_depth(24'sd1);
        drain_points();

        // One pixel per row so the row climbs far enough to saturate y upward.
        write_reg(REG_FRAME_WIDTH, 24'd1);
        write_reg(REG_FRAME_HEIGHT, 24'd4096);
        write_reg(REG_CENTER_Y, 24'd0);
        write_reg(REG_INV_FOCAL_Y, INV_MAX);
        write_reg(REG_INV_FOCAL_X, pick_inv());
        for (n = 0; n < 350; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_depth(DEPTH_W'($urandom_range(24'h7A0000, 24'h7FFFFF)));
            else
                send_depth(pick_depth());
        end
        drain_points();

        // Random phases; counters carry across so shrinking sizes hit mid-frame.
        while (depths_sent < DEPTH_TARGET)
        begin
            calm_phase = ($urandom_range(0, 4) == 0);
            shuffle_config();
            phase_len = $urandom_range(20, 120);
            for (n = 0; n < phase_len; n++)
            begin
                send_depth(pick_depth());
                if ($urandom_range(0, 199) == 0)
                    drain_points();
            end
            drain_points();
        end

        // Let any stray point show up before the verdict.
        calm_phase = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (chk.bad_points == 0 && chk.pending() == 0)
            $display("** depth_to_xyz_backprojection_top: PASSED **");
        else
            $display("** depth_to_xyz_backprojection_top: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("** depth_to_xyz_backprojection_top: FAILED **");
        $finish;
    end

endmodule
